// ===== rtl/sfq_pkg.sv =====
// Shared types and constants for the searchable FIFO queue.
`timescale 1ns / 1ps
`default_nettype none

package sfq_pkg;

    localparam int unsigned VAL_W = 32;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_SEARCH  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // Classified request handed from the front end to the back end
    typedef struct packed {
        t_op                      op;
        logic signed [VAL_W-1:0]  operand;
    } t_cmd;

    // One result item
    typedef struct packed {
        logic signed [VAL_W-1:0]  result_value;
        logic                     found;
        logic                     queue_empty;
        logic                     queue_full;
        t_status                  status;
    } t_rsp;

endpackage

`default_nettype wire

// ===== rtl/sfq_if.sv =====
// Request and result channel interfaces of the searchable FIFO queue.
`timescale 1ns / 1ps
`default_nettype none

interface sfq_req_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  req_type;
    logic signed [31:0] operand_value;

    modport source (output valid, output req_type, output operand_value, input ready);
    modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

interface sfq_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               found;
    logic               queue_empty;
    logic               queue_full;
    logic        [1:0]  status;

    modport source (output valid, output result_value, output found, output queue_empty,
                    output queue_full, output status, input ready);
    modport sink   (input valid, input result_value, input found, input queue_empty,
                    input queue_full, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/searchable_fifo_queue.sv =====
// Top level of the searchable FIFO queue: front end, back end and checks.
`timescale 1ns / 1ps
`default_nettype none

// A first-in first-out queue of DEPTH signed 32-bit words with four request
// kinds: enqueue, dequeue, peek at the oldest item and search for a key. Each
// request item gives exactly one result item carrying the dequeued or front
// value, a found flag for searches, empty/full flags after the request and a
// status (ok, underflow on an empty dequeue or peek, overflow on a full
// enqueue; rejected requests leave the queue untouched). A two-entry request
// queue in the front end takes items while the back end is busy or a result
// waits in the output register. In the back end an enqueue, and any request
// that underflows, overflows or searches an empty queue, loads its result
// from the idle state; a dequeue or peek passes through a read state since the
// storage has one registered read port; a search walks the occupied entries
// through that same port, one per cycle, compares the last one from the read
// register and then loads the result once the output register is free. The
// storage needs no clearing after reset: only occupied entries are ever read.

module searchable_fifo_queue #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sfq_req_if.sink    i_req,
    sfq_rsp_if.source  o_rsp
);
    import sfq_pkg::*;

    t_cmd  cmd;
    logic  cmd_valid;
    logic  cmd_ready;

    // request decode and buffering
    sfq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready)
    );

    // storage, pointers and execution
    sfq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .o_rsp       (o_rsp)
    );

    // a stalled item between front and back end holds still
    a_cmd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("front-to-back item changed while stalled");

    // underflow only on an empty queue, with a zero value
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ST_UNDERFLOW) |->
            o_rsp.queue_empty && (o_rsp.result_value == '0) && !o_rsp.found)
        else $error("underflow result inconsistent");

    // overflow only on a full queue
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.status == ST_OVERFLOW) |->
            o_rsp.queue_full && (o_rsp.result_value == '0))
        else $error("overflow result inconsistent");

    // empty and full are exclusive
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.queue_empty && o_rsp.queue_full))
        else $error("queue reported empty and full at once");

endmodule

`default_nettype wire

// ===== rtl/sfq_front.sv =====
// Front end: accepts request items, decodes them and holds them in a two-entry queue.
`timescale 1ns / 1ps
`default_nettype none

module sfq_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sfq_req_if.sink            i_req,
    output sfq_pkg::t_cmd      o_cmd,
    output logic               o_cmd_valid,
    input  wire logic          i_cmd_ready
);
    import sfq_pkg::*;

    t_cmd        r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        n_wp, n_rp;
    logic [1:0]  n_cnt;
    logic        push, pop;
    t_cmd        decoded;

    assign i_req.ready = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    assign push = i_req.valid && i_req.ready;
    assign pop  = o_cmd_valid && i_cmd_ready;

    always_comb begin
        decoded.op      = t_op'(i_req.req_type);
        decoded.operand = i_req.operand_value;
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop  ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= decoded;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sfq_back.sv =====
// Back end: ring storage, head/tail/count, request execution and the result register.
`timescale 1ns / 1ps
`default_nettype none

module sfq_back #(
    parameter int unsigned DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  sfq_pkg::t_cmd      i_cmd,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    sfq_rsp_if.source          o_rsp
);
    import sfq_pkg::*;

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } t_state;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] idx);
        return (idx == IW'(DEPTH - 1)) ? '0 : idx + IW'(1);
    endfunction

    logic [VAL_W-1:0]        mem [DEPTH];
    logic [VAL_W-1:0]        r_rd_data;

    t_state                  r_state, n_state;
    logic [IW-1:0]           r_head, n_head;
    logic [IW-1:0]           r_tail, n_tail;
    logic [CW-1:0]           r_count, n_count;
    logic [IW-1:0]           r_scan, n_scan;
    logic [CW-1:0]           r_left, n_left;
    logic                    r_pend, n_pend;
    logic                    r_found, n_found;
    logic signed [VAL_W-1:0] r_key, n_key;
    t_rsp                    r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    logic                    wr_en, rd_en;
    logic [IW-1:0]           rd_addr;
    logic                    out_free;
    logic                    load;
    logic signed [VAL_W-1:0] ld_value;
    logic                    ld_found;
    t_status                 ld_status;

    assign out_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_scan      = r_scan;
        n_left      = r_left;
        n_pend      = r_pend;
        n_found     = r_found;
        n_key       = r_key;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_head;
        o_cmd_ready = 1'b0;
        load        = 1'b0;
        ld_value    = '0;
        ld_found    = 1'b0;
        ld_status   = ST_OK;

        case (r_state)
            S_IDLE: begin
                o_cmd_ready = out_free;
                if (i_cmd_valid && out_free) begin
                    case (i_cmd.op)
                        OP_ENQUEUE: begin
                            load = 1'b1;
                            if (r_count == CW'(DEPTH)) begin
                                ld_status = ST_OVERFLOW;
                            end else begin
                                wr_en   = 1'b1;
                                n_tail  = f_next(r_tail);
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_DEQUEUE, OP_PEEK: begin
                            if (r_count == '0) begin
                                load      = 1'b1;
                                ld_status = ST_UNDERFLOW;
                            end else begin
                                rd_en   = 1'b1;
                                n_state = S_READ;
                                if (i_cmd.op == OP_DEQUEUE) begin
                                    n_head  = f_next(r_head);
                                    n_count = r_count - CW'(1);
                                end
                            end
                        end
                        OP_SEARCH: begin
                            if (r_count == '0) begin
                                load = 1'b1;
                            end else begin
                                n_key   = i_cmd.operand;
                                n_found = 1'b0;
                                n_scan  = r_head;
                                n_left  = r_count;
                                n_pend  = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    load     = 1'b1;
                    ld_value = r_rd_data;
                    n_state  = S_IDLE;
                end
            end
            S_SCAN: begin
                // one stored entry read per cycle, compared once its registered read data is back
                if (r_left != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_scan;
                    n_scan  = f_next(r_scan);
                    n_left  = r_left - CW'(1);
                    n_pend  = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                end
                if (r_pend && (r_rd_data == r_key)) begin
                    n_found = 1'b1;
                end
                if ((r_left == '0) && !r_pend && out_free) begin
                    load     = 1'b1;
                    ld_found = r_found;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (load) begin
            n_out.result_value = ld_value;
            n_out.found        = ld_found;
            n_out.queue_empty  = (n_count == '0);
            n_out.queue_full   = (n_count == CW'(DEPTH));
            n_out.status       = ld_status;
            n_out_valid        = 1'b1;
        end
    end

    // storage ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= i_cmd.operand;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan  <= n_scan;
        r_left  <= n_left;
        r_found <= n_found;
        r_key   <= n_key;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out.result_value;
    assign o_rsp.found        = r_out.found;
    assign o_rsp.queue_empty  = r_out.queue_empty;
    assign o_rsp.queue_full   = r_out.queue_full;
    assign o_rsp.status       = r_out.status;

endmodule

`default_nettype wire
